// ===== src/betrk_pkg.sv =====
// Shared types, codes and helper functions for the button edge and auto-repeat tracker.
`timescale 1ns / 1ps
`default_nettype none
package betrk_pkg;

  localparam int unsigned NUM_BUTTONS = 8;
  localparam int unsigned NUM_DIRS    = 4;

  localparam int unsigned DZ_W     = 15;
  localparam int unsigned DELAY_W  = 6;
  localparam int unsigned IVAL_W   = 5;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned HOLD_W   = 7;
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [DZ_W-1:0]    DZ_RST    = 15'd8192;
  localparam logic [DELAY_W-1:0] DELAY_RST = 6'd30;
  localparam logic [IVAL_W-1:0]  IVAL_RST  = 5'd12;
  localparam logic [CODE_W-1:0]  PAD_B_RST = 8'd16;
  localparam logic [CODE_W-1:0]  PAD_A_RST = 8'd17;
  localparam logic [CODE_W-1:0]  KEY_B_RST = 8'd18;
  localparam logic [CODE_W-1:0]  KEY_A_RST = 8'd19;

  localparam logic [CODE_W-1:0] CODE_UP    = 8'd0;
  localparam logic [CODE_W-1:0] CODE_DOWN  = 8'd1;
  localparam logic [CODE_W-1:0] CODE_LEFT  = 8'd2;
  localparam logic [CODE_W-1:0] CODE_RIGHT = 8'd3;
  localparam logic [CODE_W-1:0] CODE_START = 8'd4;
  localparam logic [CODE_W-1:0] CODE_ESC   = 8'd5;

  localparam int unsigned IDX_UP    = 0;
  localparam int unsigned IDX_DOWN  = 1;
  localparam int unsigned IDX_LEFT  = 2;
  localparam int unsigned IDX_RIGHT = 3;
  localparam int unsigned IDX_B     = 4;
  localparam int unsigned IDX_A     = 5;
  localparam int unsigned IDX_START = 6;
  localparam int unsigned IDX_ESC   = 7;

  typedef enum logic [1:0] {
    ST_OFF      = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_ON       = 2'd2,
    ST_RELEASED = 2'd3
  } btn_st_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_AXIS    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE = 3'd0,
    CFG_DELAY    = 3'd1,
    CFG_INTERVAL = 3'd2,
    CFG_PAD_B    = 3'd3,
    CFG_PAD_A    = 3'd4,
    CFG_KEY_B    = 3'd5,
    CFG_KEY_A    = 3'd6,
    CFG_UNUSED   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                     menu_mode;
    logic signed [AXIS_W-1:0] axis_value;
    logic                     axis_select;
    logic [CODE_W-1:0]        button_code;
    logic                     from_keyboard;
    cmd_t                     command;
  } item_t;

  typedef struct packed {
    logic [DZ_W-1:0]    deadzone;
    logic [DELAY_W-1:0] first_delay;
    logic [IVAL_W-1:0]  interval;
    logic [CODE_W-1:0]  pad_b;
    logic [CODE_W-1:0]  pad_a;
    logic [CODE_W-1:0]  key_b;
    logic [CODE_W-1:0]  key_a;
  } cfg_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] released_bits;
    logic [NUM_BUTTONS-1:0] held_bits;
    logic [NUM_BUTTONS-1:0] pressed_bits;
  } report_t;

  function automatic logic is_held(input btn_st_t s);
    return (s == ST_PRESSED) || (s == ST_ON);
  endfunction

  function automatic btn_st_t st_press(input btn_st_t s);
    return is_held(s) ? s : ST_PRESSED;
  endfunction

  function automatic btn_st_t st_release(input btn_st_t s);
    return is_held(s) ? ST_RELEASED : s;
  endfunction

endpackage
`default_nettype wire

// ===== src/betrk_update.sv =====
// Next-state and report logic for one request against the current button state.
`timescale 1ns / 1ps
`default_nettype none
module betrk_update (
  input  wire betrk_pkg::item_t                                   item,
  input  wire betrk_pkg::cfg_t                                    cfg,
  input  wire betrk_pkg::btn_st_t [betrk_pkg::NUM_BUTTONS-1:0]    st_cur,
  input  wire logic [betrk_pkg::NUM_DIRS-1:0][betrk_pkg::HOLD_W-1:0] hold_cur,
  input  wire logic signed [betrk_pkg::AXIS_W-1:0]                stick_x_cur,
  input  wire logic signed [betrk_pkg::AXIS_W-1:0]                stick_y_cur,
  output betrk_pkg::btn_st_t [betrk_pkg::NUM_BUTTONS-1:0]         st_nxt,
  output logic [betrk_pkg::NUM_DIRS-1:0][betrk_pkg::HOLD_W-1:0]   hold_nxt,
  output logic signed [betrk_pkg::AXIS_W-1:0]                     stick_x_nxt,
  output logic signed [betrk_pkg::AXIS_W-1:0]                     stick_y_nxt,
  output betrk_pkg::report_t                                      report
);

  localparam int unsigned CMP_W     = betrk_pkg::AXIS_W + 1;
  localparam int unsigned BTN_IDX_W = $clog2(betrk_pkg::NUM_BUTTONS);

  betrk_pkg::btn_st_t [betrk_pkg::NUM_BUTTONS-1:0] st_evt;
  logic [betrk_pkg::NUM_BUTTONS-1:0] match;
  logic [betrk_pkg::CODE_W-1:0]      b_code;
  logic [betrk_pkg::CODE_W-1:0]      a_code;
  logic signed [CMP_W-1:0]           v_new;
  logic signed [CMP_W-1:0]           v_old;
  logic signed [CMP_W-1:0]           dz_pos;
  logic signed [CMP_W-1:0]           dz_neg;
  logic [betrk_pkg::HOLD_W-1:0]      first_cnt;
  logic [betrk_pkg::HOLD_W-1:0]      second_cnt;
  logic [betrk_pkg::HOLD_W-1:0]      t_cnt [betrk_pkg::NUM_DIRS];
  logic [BTN_IDX_W-1:0]              neg_idx;
  logic [BTN_IDX_W-1:0]              pos_idx;

  assign b_code = item.from_keyboard ? cfg.key_b : cfg.pad_b;
  assign a_code = item.from_keyboard ? cfg.key_a : cfg.pad_a;

  always_comb begin
    match                       = '0;
    match[betrk_pkg::IDX_UP]    = (item.button_code == betrk_pkg::CODE_UP);
    match[betrk_pkg::IDX_DOWN]  = (item.button_code == betrk_pkg::CODE_DOWN);
    match[betrk_pkg::IDX_LEFT]  = (item.button_code == betrk_pkg::CODE_LEFT);
    match[betrk_pkg::IDX_RIGHT] = (item.button_code == betrk_pkg::CODE_RIGHT);
    match[betrk_pkg::IDX_B]     = (item.button_code == b_code);
    match[betrk_pkg::IDX_A]     = (item.button_code == a_code);
    match[betrk_pkg::IDX_START] = (item.button_code == betrk_pkg::CODE_START);
    match[betrk_pkg::IDX_ESC]   = item.from_keyboard &&
                                  (item.button_code == betrk_pkg::CODE_ESC);
  end

  assign v_new  = CMP_W'(item.axis_value);
  assign v_old  = item.axis_select ? CMP_W'(stick_x_cur) : CMP_W'(stick_y_cur);
  assign dz_pos = signed'({2'b00, cfg.deadzone});
  assign dz_neg = -dz_pos;
  assign neg_idx = item.axis_select ? BTN_IDX_W'(betrk_pkg::IDX_LEFT) :
                                      BTN_IDX_W'(betrk_pkg::IDX_UP);
  assign pos_idx = item.axis_select ? BTN_IDX_W'(betrk_pkg::IDX_RIGHT) :
                                      BTN_IDX_W'(betrk_pkg::IDX_DOWN);

  assign first_cnt  = betrk_pkg::HOLD_W'(cfg.first_delay);
  assign second_cnt = betrk_pkg::HOLD_W'(cfg.first_delay) + betrk_pkg::HOLD_W'(cfg.interval);

  // apply the request to the button states, hold counters and stick positions
  always_comb begin
    st_evt      = st_cur;
    hold_nxt    = hold_cur;
    stick_x_nxt = stick_x_cur;
    stick_y_nxt = stick_y_cur;
    for (int i = 0; i < betrk_pkg::NUM_DIRS; i++) begin
      t_cnt[i] = hold_cur[i] + 1'b1;
    end
    unique case (item.command)
      betrk_pkg::CMD_PRESS: begin
        for (int i = 0; i < betrk_pkg::NUM_BUTTONS; i++) begin
          if (match[i]) st_evt[i] = betrk_pkg::st_press(st_cur[i]);
        end
      end
      betrk_pkg::CMD_RELEASE: begin
        for (int i = 0; i < betrk_pkg::NUM_BUTTONS; i++) begin
          if (match[i]) st_evt[i] = betrk_pkg::st_release(st_cur[i]);
        end
      end
      betrk_pkg::CMD_AXIS: begin
        priority if (v_new <= dz_neg && v_old > dz_neg) begin
          st_evt[neg_idx] = betrk_pkg::st_press(st_cur[neg_idx]);
        end else if (v_new > dz_neg && v_old <= dz_neg) begin
          st_evt[neg_idx] = betrk_pkg::st_release(st_cur[neg_idx]);
        end else if (v_new < dz_pos && v_old >= dz_pos) begin
          st_evt[pos_idx] = betrk_pkg::st_release(st_cur[pos_idx]);
        end else if (v_new >= dz_pos && v_old < dz_pos) begin
          st_evt[pos_idx] = betrk_pkg::st_press(st_cur[pos_idx]);
        end else begin
          st_evt = st_cur;
        end
        if (item.axis_select) stick_x_nxt = item.axis_value;
        else                  stick_y_nxt = item.axis_value;
      end
      betrk_pkg::CMD_TICK: begin
        if (item.menu_mode) begin
          for (int i = 0; i < betrk_pkg::NUM_DIRS; i++) begin
            if (betrk_pkg::is_held(st_cur[i])) begin
              if (t_cnt[i] == first_cnt || t_cnt[i] == second_cnt) begin
                st_evt[i] = betrk_pkg::ST_PRESSED;
              end
              hold_nxt[i] = (t_cnt[i] >= second_cnt) ? first_cnt : t_cnt[i];
            end else begin
              hold_nxt[i] = '0;
            end
          end
        end
      end
      default: st_evt = st_cur;
    endcase
  end

  // sample the sets, then retire edges on a tick
  always_comb begin
    for (int i = 0; i < betrk_pkg::NUM_BUTTONS; i++) begin
      report.pressed_bits[i]  = (st_evt[i] == betrk_pkg::ST_PRESSED);
      report.held_bits[i]     = betrk_pkg::is_held(st_evt[i]);
      report.released_bits[i] = (st_evt[i] == betrk_pkg::ST_RELEASED);
      st_nxt[i] = st_evt[i];
      if (item.command == betrk_pkg::CMD_TICK) begin
        unique case (st_evt[i])
          betrk_pkg::ST_PRESSED:  st_nxt[i] = betrk_pkg::ST_ON;
          betrk_pkg::ST_RELEASED: st_nxt[i] = betrk_pkg::ST_OFF;
          default:                st_nxt[i] = st_evt[i];
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/button_edge_autorepeat_tracker_core.sv =====
// Top level of the button edge and auto-repeat tracker.
// Usage:
//   Requests enter on the in_ stream: in_tuser carries the command and the
//   keyboard flag, in_tdata the button code, axis select, axis value and
//   menu flag. Each request yields exactly one result on the out_ stream:
//   the pressed, held and released bit sets in up, down, left, right, B, A,
//   start, escape order.
//   Path: a request taken is held in the request register, processed
//   combinationally, and its result registered, which raises out_tvalid.
//   Throughput: one request per cycle unless stalled; the button state
//   update is a single combinational pass between the request register
//   and the result register, so a request may follow in every cycle.
//   Stall: when out_tready is low the result holds, the request register
//   fills, and in_tready drops until the result is taken.
//   Reset (rst_n low, synchronous): all buttons off, hold counters and
//   stored stick positions zero, registers at their defaults, both stages
//   empty.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr at the
//   edge; write only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module button_edge_autorepeat_tracker_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  output      logic                                    in_tready,
  // [7:0] button_code, [8] axis_select, [24:9] axis_value, [25] menu_mode
  input  wire logic [betrk_pkg::IN_TDATA_W-1:0]        in_tdata,
  // [1:0] command, [2] from_keyboard
  input  wire logic [betrk_pkg::IN_TUSER_W-1:0]        in_tuser,
  output      logic                                    out_tvalid,
  input  wire logic                                    out_tready,
  // [7:0] pressed_bits, [15:8] held_bits, [23:16] released_bits
  output      logic [betrk_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                                    cfg_we,
  input  wire logic [betrk_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  wire logic [betrk_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  betrk_pkg::cfg_t  cfg_r;
  betrk_pkg::item_t item_r;
  betrk_pkg::item_t item_in;
  logic             item_vld_r;
  logic             advance;

  betrk_pkg::btn_st_t [betrk_pkg::NUM_BUTTONS-1:0]         st_r;
  betrk_pkg::btn_st_t [betrk_pkg::NUM_BUTTONS-1:0]         st_nxt;
  logic [betrk_pkg::NUM_DIRS-1:0][betrk_pkg::HOLD_W-1:0]   hold_r;
  logic [betrk_pkg::NUM_DIRS-1:0][betrk_pkg::HOLD_W-1:0]   hold_nxt;
  logic signed [betrk_pkg::AXIS_W-1:0]                     stick_x_r;
  logic signed [betrk_pkg::AXIS_W-1:0]                     stick_x_nxt;
  logic signed [betrk_pkg::AXIS_W-1:0]                     stick_y_r;
  logic signed [betrk_pkg::AXIS_W-1:0]                     stick_y_nxt;
  betrk_pkg::report_t                                      report;
  betrk_pkg::report_t                                      out_r;
  logic                                                    out_vld_r;

  // menu_mode, axis_value, axis_select, button_code, from_keyboard, command
  assign item_in = {in_tdata[25], in_tdata[24:9], in_tdata[8], in_tdata[7:0],
                    in_tuser[2], in_tuser[1:0]};

  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone    <= betrk_pkg::DZ_RST;
      cfg_r.first_delay <= betrk_pkg::DELAY_RST;
      cfg_r.interval    <= betrk_pkg::IVAL_RST;
      cfg_r.pad_b       <= betrk_pkg::PAD_B_RST;
      cfg_r.pad_a       <= betrk_pkg::PAD_A_RST;
      cfg_r.key_b       <= betrk_pkg::KEY_B_RST;
      cfg_r.key_a       <= betrk_pkg::KEY_A_RST;
    end else if (cfg_we) begin
      unique case (betrk_pkg::cfg_idx_t'(cfg_addr))
        betrk_pkg::CFG_DEADZONE: cfg_r.deadzone    <= cfg_wdata[betrk_pkg::DZ_W-1:0];
        betrk_pkg::CFG_DELAY:    cfg_r.first_delay <= cfg_wdata[betrk_pkg::DELAY_W-1:0];
        betrk_pkg::CFG_INTERVAL: cfg_r.interval    <= cfg_wdata[betrk_pkg::IVAL_W-1:0];
        betrk_pkg::CFG_PAD_B:    cfg_r.pad_b       <= cfg_wdata[betrk_pkg::CODE_W-1:0];
        betrk_pkg::CFG_PAD_A:    cfg_r.pad_a       <= cfg_wdata[betrk_pkg::CODE_W-1:0];
        betrk_pkg::CFG_KEY_B:    cfg_r.key_b       <= cfg_wdata[betrk_pkg::CODE_W-1:0];
        betrk_pkg::CFG_KEY_A:    cfg_r.key_a       <= cfg_wdata[betrk_pkg::CODE_W-1:0];
        default:                 cfg_r             <= cfg_r;
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_in;
    end
  end

  betrk_update u_update (
    .item        (item_r),
    .cfg         (cfg_r),
    .st_cur      (st_r),
    .hold_cur    (hold_r),
    .stick_x_cur (stick_x_r),
    .stick_y_cur (stick_y_r),
    .st_nxt      (st_nxt),
    .hold_nxt    (hold_nxt),
    .stick_x_nxt (stick_x_nxt),
    .stick_y_nxt (stick_y_nxt),
    .report      (report)
  );

  // tracker state, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{default: betrk_pkg::ST_OFF};
      hold_r    <= '0;
      stick_x_r <= '0;
      stick_y_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r      <= st_nxt;
        hold_r    <= hold_nxt;
        stick_x_r <= stick_x_nxt;
        stick_y_r <= stick_y_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= report;
    end
  end

endmodule
`default_nettype wire
